// ===== hdl/efdf_pkg.sv =====
// Shared constants and types for the escaped frame deframer with Fletcher-16 check.
`default_nettype none
package efdf_pkg;

	// Header bytes covered by the checksum ahead of the payload (range 2..16)
	localparam int unsigned HEADER_BYTES = 6;

	localparam int unsigned IDX_W   = 10;
	localparam int unsigned TICK_W  = 16;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;

	// Input opcodes
	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_TICK = 1'b1;

	// Result kinds
	localparam logic KIND_DATA   = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	// Deframer phase
	localparam logic [1:0] PH_HUNT  = 2'd0;
	localparam logic [1:0] PH_FRAME = 2'd1;
	localparam logic [1:0] PH_ESC   = 2'd2;

	// Frame status codes
	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_HUNT_TO    = 3'd1;
	localparam logic [2:0] ST_ESC_BROKEN = 3'd2;
	localparam logic [2:0] ST_TOO_LONG   = 3'd3;
	localparam logic [2:0] ST_FRAME_TO   = 3'd4;
	localparam logic [2:0] ST_BAD_SUM    = 3'd5;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_START   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_END     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ESCAPE  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MAXLEN  = 3'd4;

	localparam logic [IDX_W-1:0] IDX_MAX = {IDX_W{1'b1}};

	typedef struct packed {
		logic             kind;
		logic [7:0]       data;
		logic [2:0]       status;
		logic [IDX_W-1:0] count;
	} res_t;

endpackage
`default_nettype wire

// ===== hdl/escaped_frame_deframer_fletcher_core.sv =====
// Top level: byte-stuffed frame deframer with Fletcher-16 checksum and timeouts.
`default_nettype none
// Takes one transaction per clock (a received byte or a timer tick) and produces at most
// one result per transaction: a destuffed data byte or a frame status. All per-item work
// is a single registered pass: a result goes into the output register, or into the skid
// entry while the output is stalled, and the sustained rate is one item every cycle while
// in_stall is low. Results sit in an output register backed by one skid entry; in_stall
// follows that entry, so input is held only while a stalled result has a second one
// waiting behind it, and resumes the cycle after the skid entry moves to the output.
// Registers are written through the cfg port (always ready) and take effect immediately.
module escaped_frame_deframer_fletcher_core
	import efdf_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output      logic                  in_stall,
	input  wire logic                  opcode,
	input  wire logic [7:0]            rx_byte,
	output      logic                  out_valid,
	input  wire logic                  out_stall,
	output      logic                  out_kind,
	output      logic [7:0]            out_byte,
	output      logic [2:0]            status,
	output      logic [IDX_W-1:0]      frame_count,
	input  wire logic                  cfg_valid,
	output      logic                  cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	// configuration
	logic [7:0]        start_marker_q, end_marker_q, escape_marker_q;
	logic [TICK_W-1:0] timeout_ticks_q;
	logic [IDX_W-1:0]  max_frame_bytes_q;

	// deframer state
	logic [1:0]        phase_q, phase_d;
	logic              prev_esc_q, prev_esc_d;
	logic [TICK_W-1:0] tick_q, tick_d;
	logic [IDX_W-1:0]  plain_q, plain_d;
	logic [IDX_W-1:0]  idx_q, idx_d;
	logic [7:0]        len_q, len_d;
	logic [7:0]        sum_lo_q, sum_lo_d, sum_hi_q, sum_hi_d;
	logic [7:0]        chk_lo_q, chk_lo_d, chk_hi_q, chk_hi_d;

	// output register and skid entry
	logic out_valid_q, skid_valid_q;
	res_t out_q, skid_q;

	logic in_fire;
	logic res_valid;
	res_t res;
	logic do_clear;

	// absorb path results
	logic [7:0]       abs_len;
	logic [IDX_W-1:0] abs_end;
	logic [8:0]       lo_sum, hi_sum;
	logic [7:0]       abs_sum_lo, abs_sum_hi, abs_chk_lo, abs_chk_hi;
	logic [IDX_W-1:0] abs_idx;

	logic [IDX_W-1:0] need;
	logic [IDX_W:0]   plain_inc;
	logic             frame_good;

	assign cfg_ready = 1'b1;
	assign in_stall  = skid_valid_q;
	assign in_fire   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_marker_q    <= 8'd2;
			end_marker_q      <= 8'd3;
			escape_marker_q   <= 8'd27;
			timeout_ticks_q   <= TICK_W'(1000);
			max_frame_bytes_q <= IDX_W'(255);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_START:   start_marker_q    <= cfg_data[7:0];
				REG_END:     end_marker_q      <= cfg_data[7:0];
				REG_ESCAPE:  escape_marker_q   <= cfg_data[7:0];
				REG_TIMEOUT: timeout_ticks_q   <= cfg_data[TICK_W-1:0];
				REG_MAXLEN:  max_frame_bytes_q <= cfg_data[IDX_W-1:0];
				default: ;
			endcase
		end
	end

	// Fletcher-16 byte update, else check-byte capture; frame byte 1 carries the payload length
	always_comb begin
		abs_len    = (idx_q == IDX_W'(1)) ? rx_byte : len_q;
		abs_end    = IDX_W'(HEADER_BYTES) + IDX_W'(abs_len);
		abs_sum_lo = sum_lo_q;
		abs_sum_hi = sum_hi_q;
		abs_chk_lo = chk_lo_q;
		abs_chk_hi = chk_hi_q;
		lo_sum     = 9'(sum_lo_q) + 9'(rx_byte);
		if (lo_sum >= 9'd255)
			lo_sum = lo_sum - 9'd255;
		hi_sum     = 9'(sum_hi_q) + lo_sum;
		if (hi_sum >= 9'd255)
			hi_sum = hi_sum - 9'd255;
		if (idx_q < abs_end) begin
			abs_sum_lo = lo_sum[7:0];
			abs_sum_hi = hi_sum[7:0];
		end else if (idx_q == abs_end) begin
			abs_chk_lo = rx_byte;
		end else if (idx_q == abs_end + IDX_W'(1)) begin
			abs_chk_hi = rx_byte;
		end
		abs_idx = (idx_q != IDX_MAX) ? idx_q + IDX_W'(1) : idx_q;
	end

	assign need       = IDX_W'(HEADER_BYTES) + IDX_W'(len_q) + IDX_W'(2);
	assign frame_good = (idx_q >= need) && (chk_lo_q == sum_lo_q) && (chk_hi_q == sum_hi_q);
	assign plain_inc  = {1'b0, plain_q} + (IDX_W+1)'(1);

	always_comb begin
		phase_d    = phase_q;
		prev_esc_d = prev_esc_q;
		tick_d     = tick_q;
		plain_d    = plain_q;
		idx_d      = idx_q;
		len_d      = len_q;
		sum_lo_d   = sum_lo_q;
		sum_hi_d   = sum_hi_q;
		chk_lo_d   = chk_lo_q;
		chk_hi_d   = chk_hi_q;
		res_valid  = 1'b0;
		res        = '0;
		do_clear   = 1'b0;

		if (in_fire) begin
			if (opcode == OP_TICK) begin
				if (tick_q >= timeout_ticks_q) begin
					do_clear   = 1'b1;
					res_valid  = 1'b1;
					res.kind   = KIND_STATUS;
					case (phase_q)
						PH_HUNT: res.status = ST_HUNT_TO;
						PH_ESC:  res.status = ST_ESC_BROKEN;
						default: res.status = ST_FRAME_TO;
					endcase
				end else begin
					tick_d = tick_q + TICK_W'(1);
				end
			end else begin
				case (phase_q)
					PH_HUNT: begin
						if (rx_byte == start_marker_q && !prev_esc_q)
							do_clear = 1'b1;
						else
							prev_esc_d = (rx_byte == escape_marker_q);
					end
					PH_ESC: begin
						phase_d   = PH_FRAME;
						len_d     = abs_len;
						sum_lo_d  = abs_sum_lo;
						sum_hi_d  = abs_sum_hi;
						chk_lo_d  = abs_chk_lo;
						chk_hi_d  = abs_chk_hi;
						idx_d     = abs_idx;
						res_valid = 1'b1;
						res.kind  = KIND_DATA;
						res.data  = rx_byte;
					end
					PH_FRAME: begin
						// end marker wins over escape marker
						if (rx_byte == end_marker_q) begin
							do_clear   = 1'b1;
							res_valid  = 1'b1;
							res.kind   = KIND_STATUS;
							res.status = frame_good ? ST_OK : ST_BAD_SUM;
							res.count  = frame_good ? plain_q : '0;
						end else if (rx_byte == escape_marker_q) begin
							phase_d = PH_ESC;
						end else if (plain_inc > {1'b0, max_frame_bytes_q}) begin
							do_clear   = 1'b1;
							res_valid  = 1'b1;
							res.kind   = KIND_STATUS;
							res.status = ST_TOO_LONG;
						end else begin
							plain_d   = plain_inc[IDX_W-1:0];
							len_d     = abs_len;
							sum_lo_d  = abs_sum_lo;
							sum_hi_d  = abs_sum_hi;
							chk_lo_d  = abs_chk_lo;
							chk_hi_d  = abs_chk_hi;
							idx_d     = abs_idx;
							res_valid = 1'b1;
							res.kind  = KIND_DATA;
							res.data  = rx_byte;
						end
					end
					default: do_clear = 1'b1;
				endcase
			end
		end

		if (do_clear) begin
			// a start marker in hunt (or an unused phase) opens a frame; every clear that reports a status goes back to hunting
			phase_d    = (res_valid) ? PH_HUNT : PH_FRAME;
			prev_esc_d = 1'b0;
			tick_d     = '0;
			plain_d    = '0;
			idx_d      = '0;
			len_d      = '0;
			sum_lo_d   = '0;
			sum_hi_d   = '0;
			chk_lo_d   = '0;
			chk_hi_d   = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HUNT;
			prev_esc_q <= 1'b0;
			tick_q     <= '0;
			plain_q    <= '0;
			idx_q      <= '0;
			len_q      <= '0;
			sum_lo_q   <= '0;
			sum_hi_q   <= '0;
			chk_lo_q   <= '0;
			chk_hi_q   <= '0;
		end else begin
			phase_q    <= phase_d;
			prev_esc_q <= prev_esc_d;
			tick_q     <= tick_d;
			plain_q    <= plain_d;
			idx_q      <= idx_d;
			len_q      <= len_d;
			sum_lo_q   <= sum_lo_d;
			sum_hi_q   <= sum_hi_d;
			chk_lo_q   <= chk_lo_d;
			chk_hi_q   <= chk_hi_d;
		end
	end

	// Output register with one skid entry behind it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || !out_stall) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= res_valid;
			end
		end else if (res_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || !out_stall) begin
			out_q <= skid_valid_q ? skid_q : res;
		end else if (res_valid) begin
			skid_q <= res;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_kind    = out_q.kind;
	assign out_byte    = out_q.data;
	assign status      = out_q.status;
	assign frame_count = out_q.count;

	// skid entry only fills behind a held result
	assert property (@(posedge clk) disable iff (!arst_n) skid_valid_q |-> out_valid_q)
		else $error("skid entry valid without output result");

	// hunting always starts from a cleared frame
	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_HUNT) |-> (idx_q == '0 && plain_q == '0 && len_q == '0))
		else $error("frame counters not cleared while hunting");

	// escape history is only tracked while hunting
	assert property (@(posedge clk) disable iff (!arst_n) (phase_q != PH_HUNT) |-> !prev_esc_q)
		else $error("escape history left set inside a frame");

	// mod-255 sums never reach 255
	assert property (@(posedge clk) disable iff (!arst_n)
		(sum_lo_q != 8'd255) && (sum_hi_q != 8'd255))
		else $error("Fletcher sum out of range");

	// a stalled result with an idle skid entry never gets overwritten
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall && !skid_valid_q && res_valid) |=> skid_valid_q)
		else $error("result lost under output stall");

endmodule
`default_nettype wire
